// ----- hdl/brl_pkg.sv -----
// ---------------------------------------------------------------------------
// brl_pkg
// Shared types and codes for the block range reader/writer lock table.
// ---------------------------------------------------------------------------
package brl_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	// answer kinds
	localparam logic [1:0] ANS_ACQ   = 2'd0;
	localparam logic [1:0] ANS_REL   = 2'd1;
	localparam logic [1:0] ANS_GRANT = 2'd2;

	// status codes
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_WAIT      = 3'd1;
	localparam logic [2:0] STS_BADRANGE  = 3'd2;
	localparam logic [2:0] STS_FULL      = 3'd3;
	localparam logic [2:0] STS_BADHANDLE = 3'd4;

	// result select
	localparam logic [2:0] OSEL_BADRANGE = 3'd0;
	localparam logic [2:0] OSEL_FULL     = 3'd1;
	localparam logic [2:0] OSEL_ACQ      = 3'd2;
	localparam logic [2:0] OSEL_BADH     = 3'd3;
	localparam logic [2:0] OSEL_REL      = 3'd4;
	localparam logic [2:0] OSEL_GRANT    = 3'd5;

	localparam logic KIND_ACQ = 1'b0;

	typedef struct packed {
		logic        kind;
		logic [63:0] offset;
		logic [63:0] length;
		logic        write_mode;
		logic [3:0]  handle;
	} req_t;

	typedef struct packed {
		logic [1:0] answer_kind;
		logic [2:0] status;
		logic [3:0] slot;
		logic [4:0] active_total;
		logic [4:0] waiting_total;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic       cap;
		logic       calc_a;
		logic       calc_b;
		logic       alloc;
		logic       rel_free;
		logic       scan;
		logic       load;
		logic [2:0] osel;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic has_free;
		logic h_active;
		logic scan_done;
		logic n_zero;
		logic g_last;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/brl_ctrl.sv -----
// ---------------------------------------------------------------------------
// brl_ctrl
// Sequencer for acquire and release items; drives the datapath by commands.
// ---------------------------------------------------------------------------
module brl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_kind,
	output logic          req_stall,
	input  brl_pkg::sts_t sts,
	output brl_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CALC_A = 4'd1;
	localparam logic [3:0] S_CALC_B = 4'd2;
	localparam logic [3:0] S_CHK    = 4'd3;
	localparam logic [3:0] S_DECIDE = 4'd4;
	localparam logic [3:0] S_RELCHK = 4'd5;
	localparam logic [3:0] S_SCAN   = 4'd6;
	localparam logic [3:0] S_EMREL  = 4'd7;
	localparam logic [3:0] S_EMG    = 4'd8;

	logic [3:0] state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = (req_kind == brl_pkg::KIND_ACQ) ? S_CALC_A : S_RELCHK;
				end
			end
			S_CALC_A: begin
				cmd.calc_a = 1'b1;
				state_d = S_CALC_B;
			end
			S_CALC_B: begin
				cmd.calc_b = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.bad) begin
					if (sts.out_free) begin
						cmd.load = 1'b1;
						cmd.osel = brl_pkg::OSEL_BADRANGE;
						state_d = S_IDLE;
					end
				end else if (!sts.has_free) begin
					if (sts.out_free) begin
						cmd.load = 1'b1;
						cmd.osel = brl_pkg::OSEL_FULL;
						state_d = S_IDLE;
					end
				end else begin
					cmd.alloc = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.osel = brl_pkg::OSEL_ACQ;
					state_d = S_IDLE;
				end
			end
			S_RELCHK: begin
				if (!sts.h_active) begin
					if (sts.out_free) begin
						cmd.load = 1'b1;
						cmd.osel = brl_pkg::OSEL_BADH;
						state_d = S_IDLE;
					end
				end else begin
					cmd.rel_free = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_EMREL;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_EMREL: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.osel = brl_pkg::OSEL_REL;
					state_d = sts.n_zero ? S_IDLE : S_EMG;
				end
			end
			S_EMG: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.osel = brl_pkg::OSEL_GRANT;
					if (sts.g_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/brl_dp.sv -----
// ---------------------------------------------------------------------------
// brl_dp
// Slot table, wait queue, conflict compare against all slots, result register.
// ---------------------------------------------------------------------------
module brl_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  brl_pkg::req_t req_data,
	input  logic [4:0]    block_shift,
	input  brl_pkg::cmd_t cmd,
	output brl_pkg::sts_t sts,
	input  logic          rsp_stall,
	output logic          rsp_valid,
	output brl_pkg::rsp_t rsp_data
);

	localparam int IW = brl_pkg::IDX_W;
	localparam int CW = brl_pkg::CNT_W;
	localparam int N  = brl_pkg::SLOTS;

	// input item
	logic [63:0] off_q, len_q, lm1_q, end_q;
	logic        wm_q, zero_q, bad_q;
	logic [3:0]  h_q;

	// slot table
	logic [63:0]   first_q [N];
	logic [63:0]   last_q  [N];
	logic          wr_q    [N];
	logic [IW-1:0] worder_q [N];
	logic [IW-1:0] gl_q    [N];
	logic [N-1:0]  act_q, wait_m_q, kept_q;
	logic [CW-1:0] actc_q, waitc_q, i_q, keep_q, n_q, k_q;
	logic [IW-1:0] c_q;

	logic          out_v_q;
	brl_pkg::rsp_t out_q;

	logic [IW-1:0] cidx, fidx, widx;
	logic [N-1:0]  conf, blk_mask;
	logic          hit, has_free;
	logic [64:0]   sum;
	logic          out_free;

	assign widx = worder_q[i_q[IW-1:0]];
	assign cidx = cmd.scan ? widx : c_q;
	assign sum  = {1'b0, off_q} + {1'b0, lm1_q};

	// candidate span against every slot at once
	always_comb begin
		for (int j = 0; j < N; j++) begin
			conf[j] = (first_q[cidx] <= last_q[j]) && (first_q[j] <= last_q[cidx]) &&
				(wr_q[cidx] || wr_q[j]);
		end
	end

	assign blk_mask = cmd.scan ? (act_q | kept_q) : (act_q | wait_m_q);
	assign hit = |(conf & blk_mask);

	always_comb begin
		fidx = '0;
		for (int j = N - 1; j >= 0; j--) begin
			if (!act_q[j] && !wait_m_q[j]) begin
				fidx = IW'(j);
			end
		end
	end
	assign has_free = ~&(act_q | wait_m_q);

	assign out_free = !out_v_q || !rsp_stall;

	assign sts.bad       = bad_q;
	assign sts.has_free  = has_free;
	assign sts.h_active  = act_q[h_q[IW-1:0]];
	assign sts.scan_done = (i_q == waitc_q);
	assign sts.n_zero    = (n_q == '0);
	assign sts.g_last    = ((k_q + CW'(1)) == n_q);
	assign sts.out_free  = out_free;

	assign rsp_valid = out_v_q;
	assign rsp_data  = out_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= '0;
			wait_m_q <= '0;
			kept_q   <= '0;
			actc_q   <= '0;
			waitc_q  <= '0;
			i_q      <= '0;
			keep_q   <= '0;
			n_q      <= '0;
			k_q      <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			if (cmd.load && cmd.osel == brl_pkg::OSEL_ACQ) begin
				if (!hit) begin
					act_q[c_q] <= 1'b1;
					actc_q     <= actc_q + CW'(1);
				end else begin
					wait_m_q[c_q] <= 1'b1;
					waitc_q       <= waitc_q + CW'(1);
				end
			end
			if (cmd.rel_free) begin
				act_q[h_q[IW-1:0]] <= 1'b0;
				actc_q <= actc_q - CW'(1);
				i_q    <= '0;
				keep_q <= '0;
				n_q    <= '0;
				k_q    <= '0;
				kept_q <= '0;
			end
			if (cmd.scan) begin
				i_q <= i_q + CW'(1);
				if (hit) begin
					kept_q[widx] <= 1'b1;
					keep_q       <= keep_q + CW'(1);
				end else begin
					act_q[widx]    <= 1'b1;
					wait_m_q[widx] <= 1'b0;
					n_q            <= n_q + CW'(1);
				end
			end
			if (cmd.load && cmd.osel == brl_pkg::OSEL_GRANT) begin
				actc_q  <= actc_q + CW'(1);
				waitc_q <= waitc_q - CW'(1);
				k_q     <= k_q + CW'(1);
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			off_q <= req_data.offset;
			len_q <= req_data.length;
			wm_q  <= req_data.write_mode;
			h_q   <= req_data.handle;
		end
		if (cmd.calc_a) begin
			lm1_q  <= len_q - 64'd1;
			zero_q <= (len_q == 64'd0);
		end
		if (cmd.calc_b) begin
			end_q <= sum[63:0];
			bad_q <= zero_q || sum[64];
		end
		if (cmd.alloc) begin
			c_q            <= fidx;
			first_q[fidx]  <= off_q >> block_shift;
			last_q[fidx]   <= end_q >> block_shift;
			wr_q[fidx]     <= wm_q;
		end
		if (cmd.load && cmd.osel == brl_pkg::OSEL_ACQ && hit) begin
			worder_q[waitc_q[IW-1:0]] <= c_q;
		end
		if (cmd.scan) begin
			if (hit) begin
				worder_q[keep_q[IW-1:0]] <= widx;
			end else begin
				gl_q[n_q[IW-1:0]] <= widx;
			end
		end
		if (cmd.load) begin
			case (cmd.osel)
				brl_pkg::OSEL_BADRANGE: begin
					out_q <= {brl_pkg::ANS_ACQ, brl_pkg::STS_BADRANGE, 4'd0,
						actc_q, waitc_q, 1'b1};
				end
				brl_pkg::OSEL_FULL: begin
					out_q <= {brl_pkg::ANS_ACQ, brl_pkg::STS_FULL, 4'd0,
						actc_q, waitc_q, 1'b1};
				end
				brl_pkg::OSEL_ACQ: begin
					if (!hit) begin
						out_q <= {brl_pkg::ANS_ACQ, brl_pkg::STS_OK, 4'(c_q),
							actc_q + CW'(1), waitc_q, 1'b1};
					end else begin
						out_q <= {brl_pkg::ANS_ACQ, brl_pkg::STS_WAIT, 4'(c_q),
							actc_q, waitc_q + CW'(1), 1'b1};
					end
				end
				brl_pkg::OSEL_BADH: begin
					out_q <= {brl_pkg::ANS_REL, brl_pkg::STS_BADHANDLE, h_q,
						actc_q, waitc_q, 1'b1};
				end
				brl_pkg::OSEL_REL: begin
					out_q <= {brl_pkg::ANS_REL, brl_pkg::STS_OK, h_q,
						actc_q, waitc_q, n_q == '0};
				end
				brl_pkg::OSEL_GRANT: begin
					out_q <= {brl_pkg::ANS_GRANT, brl_pkg::STS_OK, 4'(gl_q[k_q[IW-1:0]]),
						actc_q + CW'(1), waitc_q - CW'(1), (k_q + CW'(1)) == n_q};
				end
				default: begin
					out_q <= out_q;
				end
			endcase
		end
	end

endmodule

// ----- hdl/block_range_rw_lock_arbiter.sv -----
// ---------------------------------------------------------------------------
// block_range_rw_lock_arbiter
// Reader/writer lock table over block ranges with FIFO-fair wait queue.
// ---------------------------------------------------------------------------
//  channel | signals                         | direction
//  req     | req_valid, req_stall, req_data  | in  (acquire / release item)
//  rsp     | rsp_valid, rsp_stall, rsp_data  | out (answers and grants)
//  apb     | psel..pready                    | in  (block_shift at 0x0)
//
// Acquire: accept, end add split (length minus one, then sum), slot write,
//   compare; an invalid range or a full table answers at the slot write.
// Release: W waiters scanned one per cycle against all
//   16 slots by the shared span comparator, G grants emitted one per cycle unless the result stalls.
// One item in flight; the next is taken while the last result waits.
// A stalled result holds the emit sequencer. Reset empties the table.
// ---------------------------------------------------------------------------
module block_range_rw_lock_arbiter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  brl_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output brl_pkg::rsp_t rsp_data,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic [4:0]    shift_q;
	brl_pkg::cmd_t cmd;
	brl_pkg::sts_t sts;

	assign pready = 1'b1;
	assign prdata = {27'd0, shift_q};

	// single register at address 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 5'd12;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			shift_q <= pwdata[4:0];
		end
	end

	brl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_kind  (req_data.kind),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	brl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_data    (req_data),
		.block_shift (shift_q),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.rsp_data    (rsp_data)
	);

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (6'(rsp_data.active_total) + 6'(rsp_data.waiting_total)) <= 6'd16)
		else $error("active plus waiting exceeds slot count");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item taken while one is in work");

	a_badh_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == brl_pkg::STS_BADHANDLE |->
			rsp_data.answer_kind == brl_pkg::ANS_REL)
		else $error("invalid handle on a non-release answer");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.answer_kind == brl_pkg::ANS_GRANT |->
			rsp_data.status == brl_pkg::STS_OK && rsp_data.active_total != 5'd0)
		else $error("grant with bad status or no holder");

endmodule
